// ----- design/rmth_pkg.sv -----
// rmth_pkg: shared constants, types and helpers for the running median core
// no dependencies
package rmth_pkg;

  localparam int CAPACITY   = 1024;
  localparam int HEAP_DEPTH = (CAPACITY + 1) / 2;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int SIZE_W     = $clog2(HEAP_DEPTH + 1);
  localparam int IDX_W      = ADDR_W + 2;
  localparam int DATA_W     = 32;
  localparam int COUNT_W    = 11;
  localparam int TOT_W      = SIZE_W + 1;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic {
    HOP_PUSH,
    HOP_REPLACE
  } heap_op_t;

  typedef struct packed {
    logic                     start;
    heap_op_t                 op;
    logic signed [DATA_W-1:0] value;
    logic [SIZE_W-1:0]        size;
  } heap_cmd_t;

  typedef struct packed {
    logic                     busy;
    logic signed [DATA_W-1:0] top;
  } heap_stat_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_UP,
    H_FIN,
    H_RL,
    H_RR,
    H_CMP
  } heap_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_CHK,
    ST_SWAP,
    ST_OUT
  } core_state_t;

  // ordering: a sits above b in a max heap (is_max) or a min heap
  function automatic logic above(input logic signed [DATA_W-1:0] a,
                                 input logic signed [DATA_W-1:0] b,
                                 input logic is_max);
    above = is_max ? (a > b) : (a < b);
  endfunction

endpackage

// ----- design/running_median_two_heaps_core.sv -----
// running_median_two_heaps_core: top level, sequencing of the two heaps and stream ports
// depends on rmth_pkg and rmth_heap
//
// Streams signed 32-bit words in and answers each with the lower median of all
// words taken so far, the count held and an overflow flag (the word is dropped
// once 1024 words are held). One word is processed at a time: a push walks up
// the tree at one level per cycle, and a top exchange then walks both heaps down
// in parallel, each level taking two child reads through the single ram read
// port, then the compare and write. A dropped word skips the heaps; any other
// word's processing time is set by the sift up depth and by whether a top
// exchange and its sift down follow, plus any wait on out_tready. A finished
// result waits in the output register while the next word is accepted. No
// clearing pass is needed after reset.
module running_median_two_heaps_core
  import rmth_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [DATA_W-1:0]      in_tdata,   // [31:0] value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [31:0] median, [42:32] count, [43] overflow
);

  core_state_t       state_r, state_nxt;
  logic [SIZE_W-1:0] lo_size_r, lo_size_nxt, up_size_r, up_size_nxt;
  logic              ovf_r, ovf_nxt;
  logic              oval_r, oval_nxt;
  logic [OUT_TDATA_W-1:0] odata_r, odata_nxt;
  heap_cmd_t         lo_cmd, up_cmd;
  heap_stat_t        lo_stat, up_stat;
  logic [TOT_W-1:0]  total;
  logic signed [DATA_W-1:0] median;

  rmth_heap u_lo (.clk(clk), .rst_n(rst_n), .is_max(1'b1), .cmd(lo_cmd), .stat(lo_stat));
  rmth_heap u_up (.clk(clk), .rst_n(rst_n), .is_max(1'b0), .cmd(up_cmd), .stat(up_stat));

  assign total     = TOT_W'(lo_size_r) + TOT_W'(up_size_r);
  assign median    = (lo_size_r != '0) ? lo_stat.top : '0;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;

  always_comb begin
    state_nxt   = state_r;
    lo_size_nxt = lo_size_r;
    up_size_nxt = up_size_r;
    ovf_nxt     = ovf_r;
    oval_nxt    = oval_r;
    odata_nxt   = odata_r;
    lo_cmd      = '0;
    up_cmd      = '0;
    if (oval_r && out_tready) begin
      oval_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ovf_nxt   = 1'b0;
          state_nxt = ST_PUSH;
          if (32'(total) >= 32'(CAPACITY)) begin
            ovf_nxt   = 1'b1;
            state_nxt = ST_OUT;
          end else if (lo_size_r == up_size_r) begin
            if (32'(lo_size_r) < 32'(HEAP_DEPTH)) begin
              lo_cmd      = '{1'b1, HOP_PUSH, $signed(in_tdata), lo_size_r};
              lo_size_nxt = lo_size_r + 1'b1;
            end else begin
              ovf_nxt   = 1'b1;
              state_nxt = ST_OUT;
            end
          end else begin
            if (32'(up_size_r) < 32'(CAPACITY / 2)) begin
              up_cmd      = '{1'b1, HOP_PUSH, $signed(in_tdata), up_size_r};
              up_size_nxt = up_size_r + 1'b1;
            end else begin
              ovf_nxt   = 1'b1;
              state_nxt = ST_OUT;
            end
          end
        end
      end
      ST_PUSH: begin
        if (!lo_stat.busy && !up_stat.busy) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        state_nxt = ST_OUT;
        if (lo_size_r != '0 && up_size_r != '0 && lo_stat.top > up_stat.top) begin
          lo_cmd    = '{1'b1, HOP_REPLACE, up_stat.top, lo_size_r};
          up_cmd    = '{1'b1, HOP_REPLACE, lo_stat.top, up_size_r};
          state_nxt = ST_SWAP;
        end
      end
      ST_SWAP: begin
        if (!lo_stat.busy && !up_stat.busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!oval_r || out_tready) begin
          oval_nxt  = 1'b1;
          odata_nxt = {{(OUT_TDATA_W - DATA_W - COUNT_W - 1){1'b0}}, ovf_r,
                       COUNT_W'(total), median};
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      lo_size_r <= '0;
      up_size_r <= '0;
      oval_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      lo_size_r <= lo_size_nxt;
      up_size_r <= up_size_nxt;
      oval_r    <= oval_nxt;
    end
    ovf_r   <= ovf_nxt;
    odata_r <= odata_nxt;
  end

  // lower heap holds the same count or one more
  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (lo_size_r == up_size_r) || (lo_size_r == up_size_r + 1'b1))
    else $error("heap sizes out of balance");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total) <= 32'(CAPACITY))
    else $error("store holds more than capacity");

  // a word is only taken when both heaps are quiet
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!lo_stat.busy && !up_stat.busy))
    else $error("word accepted while a heap is busy");

  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && ovf_r) |-> (32'(total) == 32'(CAPACITY)))
    else $error("overflow flagged below capacity");

endmodule

// ----- design/rmth_ram.sv -----
// rmth_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module rmth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/rmth_heap.sv -----
// rmth_heap: one binary heap held in a ram; push with sift up, replace top with sift down
// depends on rmth_pkg and rmth_ram
module rmth_heap
  import rmth_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       is_max,
  input  heap_cmd_t  cmd,
  output heap_stat_t stat
);

  heap_state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]        pos_r, pos_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [SIZE_W-1:0]        size_r, size_nxt;
  logic signed [DATA_W-1:0] ldata_r, ldata_nxt;
  logic                     hasr_r, hasr_nxt;
  logic signed [DATA_W-1:0] top_r;

  logic                     we;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic signed [DATA_W-1:0] wdata;
  logic [DATA_W-1:0]        rdata_raw;
  logic signed [DATA_W-1:0] rdata;

  logic [ADDR_W-1:0]        parent, cmd_parent, grand;
  logic [IDX_W-1:0]         lidx, ridx;
  logic                     pick_l, pick_r;

  rmth_ram #(.WIDTH(DATA_W), .DEPTH(HEAP_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata      = $signed(rdata_raw);
  assign parent     = (pos_r - 1'b1) >> 1;
  assign grand      = (parent - 1'b1) >> 1;
  assign cmd_parent = (cmd.size[ADDR_W-1:0] - 1'b1) >> 1;
  assign lidx       = {1'b0, pos_r, 1'b1};
  assign ridx       = lidx + 1'b1;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    size_nxt  = size_r;
    ldata_nxt = ldata_r;
    hasr_nxt  = hasr_r;
    we        = 1'b0;
    waddr     = pos_r;
    wdata     = val_r;
    raddr     = parent;
    pick_l    = 1'b0;
    pick_r    = 1'b0;
    case (state_r)
      H_IDLE: begin
        if (cmd.start) begin
          val_nxt  = cmd.value;
          size_nxt = cmd.size;
          if (cmd.op == HOP_PUSH) begin
            pos_nxt = cmd.size[ADDR_W-1:0];
            if (cmd.size == '0) begin
              we    = 1'b1;
              waddr = '0;
              wdata = cmd.value;
            end else begin
              raddr     = cmd_parent;
              state_nxt = H_UP;
            end
          end else begin
            pos_nxt   = '0;
            state_nxt = H_RL;
          end
        end
      end
      H_UP: begin
        // hole moves up while the new value beats its parent
        we = 1'b1;
        if (above(val_r, rdata, is_max)) begin
          wdata   = rdata;
          pos_nxt = parent;
          raddr   = grand;
          if (parent == '0) begin
            state_nxt = H_FIN;
          end
        end else begin
          state_nxt = H_IDLE;
        end
      end
      H_FIN: begin
        we        = 1'b1;
        state_nxt = H_IDLE;
      end
      H_RL: begin
        raddr = lidx[ADDR_W-1:0];
        if (lidx < IDX_W'(size_r)) begin
          state_nxt = H_RR;
        end else begin
          we        = 1'b1;
          state_nxt = H_IDLE;
        end
      end
      H_RR: begin
        ldata_nxt = rdata;
        raddr     = ridx[ADDR_W-1:0];
        hasr_nxt  = ridx < IDX_W'(size_r);
        state_nxt = H_CMP;
      end
      H_CMP: begin
        pick_l = above(ldata_r, val_r, is_max);
        pick_r = hasr_r && above(rdata, pick_l ? ldata_r : val_r, is_max);
        we     = 1'b1;
        if (pick_r) begin
          wdata     = rdata;
          pos_nxt   = ridx[ADDR_W-1:0];
          state_nxt = H_RL;
        end else if (pick_l) begin
          wdata     = ldata_r;
          pos_nxt   = lidx[ADDR_W-1:0];
          state_nxt = H_RL;
        end else begin
          state_nxt = H_IDLE;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    size_r  <= size_nxt;
    ldata_r <= ldata_nxt;
    hasr_r  <= hasr_nxt;
    if (we && waddr == '0) begin
      top_r <= wdata;
    end
  end

  assign stat.busy = (state_r != H_IDLE);
  assign stat.top  = top_r;

endmodule

// ----- dv/testbench.sv -----
// testbench: checks the running median core against an in-bench two-heap predictor
// depends on rmth_pkg and running_median_two_heaps_core
`timescale 1ns / 1ps
module testbench;
  import rmth_pkg::*;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  running_median_two_heaps_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  typedef struct packed {
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] median;
    logic                     overflow;
  } median_res_t;

  // predictor state
  logic signed [DATA_W-1:0] lo_heap [HEAP_DEPTH];
  logic signed [DATA_W-1:0] hi_heap [HEAP_DEPTH];
  int lo_n, hi_n;

  logic [DATA_W-1:0] word_q [$];
  median_res_t       median_q [$];
  int errors, n_out, n_ovf;
  int idle_pct, stall_pct;
  longint cycles;

  function automatic bit is_above(logic signed [DATA_W-1:0] a,
                                  logic signed [DATA_W-1:0] b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  task automatic sift_up_lo(int p);
    int par;
    logic signed [DATA_W-1:0] t;
    while (p > 0) begin
      par = (p - 1) / 2;
      if (!is_above(lo_heap[p], lo_heap[par], 1)) break;
      t = lo_heap[p]; lo_heap[p] = lo_heap[par]; lo_heap[par] = t;
      p = par;
    end
  endtask

  task automatic sift_up_hi(int p);
    int par;
    logic signed [DATA_W-1:0] t;
    while (p > 0) begin
      par = (p - 1) / 2;
      if (!is_above(hi_heap[p], hi_heap[par], 0)) break;
      t = hi_heap[p]; hi_heap[p] = hi_heap[par]; hi_heap[par] = t;
      p = par;
    end
  endtask

  task automatic sift_down_lo();
    int p, l, r, b;
    logic signed [DATA_W-1:0] t;
    p = 0;
    forever begin
      l = 2 * p + 1; r = l + 1; b = p;
      if (l < lo_n && is_above(lo_heap[l], lo_heap[b], 1)) b = l;
      if (r < lo_n && is_above(lo_heap[r], lo_heap[b], 1)) b = r;
      if (b == p) break;
      t = lo_heap[p]; lo_heap[p] = lo_heap[b]; lo_heap[b] = t;
      p = b;
    end
  endtask

  task automatic sift_down_hi();
    int p, l, r, b;
    logic signed [DATA_W-1:0] t;
    p = 0;
    forever begin
      l = 2 * p + 1; r = l + 1; b = p;
      if (l < hi_n && is_above(hi_heap[l], hi_heap[b], 0)) b = l;
      if (r < hi_n && is_above(hi_heap[r], hi_heap[b], 0)) b = r;
      if (b == p) break;
      t = hi_heap[p]; hi_heap[p] = hi_heap[b]; hi_heap[b] = t;
      p = b;
    end
  endtask

  task automatic predict_median(logic signed [DATA_W-1:0] v);
    median_res_t r;
    logic signed [DATA_W-1:0] t;
    r.overflow = 0;
    if (lo_n + hi_n >= CAPACITY) begin
      r.overflow = 1;
    end else if (lo_n == hi_n) begin
      lo_heap[lo_n] = v; sift_up_lo(lo_n); lo_n++;
    end else begin
      hi_heap[hi_n] = v; sift_up_hi(hi_n); hi_n++;
    end
    if (!r.overflow && lo_n > 0 && hi_n > 0 && lo_heap[0] > hi_heap[0]) begin
      t = lo_heap[0]; lo_heap[0] = hi_heap[0]; hi_heap[0] = t;
      sift_down_lo();
      sift_down_hi();
    end
    r.median = (lo_n > 0) ? lo_heap[0] : '0;
    r.count = COUNT_W'(lo_n + hi_n);
    median_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_out);
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("timeout");
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) predict_median(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (word_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_tvalid <= 1;
          in_tdata <= word_q.pop_front();
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    median_res_t want;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_out++;
        if (median_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = median_q.pop_front();
          if ($signed(out_tdata[31:0]) != want.median)
            report_mismatch("median", $signed(out_tdata[31:0]), want.median);
          if (out_tdata[42:32] != want.count)
            report_mismatch("count", out_tdata[42:32], want.count);
          if (out_tdata[43] != want.overflow)
            report_mismatch("overflow", out_tdata[43], want.overflow);
          if (want.overflow) n_ovf++;
          if (out_tdata[47:44] != 0) report_mismatch("pad bits", out_tdata[47:44], 0);
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic wait_drained();
    while (word_q.size() > 0 || in_tvalid || median_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    logic [DATA_W-1:0] w;
    int k;
    in_tvalid = 0; in_tdata = '0; out_tready = 0;
    errors = 0; n_out = 0; n_ovf = 0;
    idle_pct = 0; stall_pct = 0;
    lo_n = 0; hi_n = 0;
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, duplicates, swaps both ways
    word_q.push_back(32'h8000_0000);
    word_q.push_back(32'h7fff_ffff);
    word_q.push_back(32'h0000_0000);
    word_q.push_back(32'hffff_ffff);
    word_q.push_back(32'h0000_0001);
    word_q.push_back(32'h7fff_ffff);
    word_q.push_back(32'h8000_0000);
    word_q.push_back(32'h5555_5555);
    word_q.push_back(32'haaaa_aaaa);
    for (k = 0; k < 6; k++) word_q.push_back(32'd5);
    for (k = 0; k < 5; k++) word_q.push_back(32'd100 - k);

    // random phases, mostly narrow ranges so duplicates and ties occur
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 67; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 67; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      for (k = 0; k < 170; k++) begin
        case ($urandom_range(3))
          0: w = $urandom();
          1: w = $urandom_range(40) - 20;
          2: w = {$urandom_range(1) ? 1'b1 : 1'b0, 31'($urandom_range(7))};
          default: w = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
        word_q.push_back(w);
      end
      wait_drained();
    end

    repeat (60) @(posedge clk);

    $display("covered %0d results over four idle/stall mixes, %0d full-store drops",
             n_out, n_ovf);
    if (errors == 0 && median_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
